[sv/chpt_pkg.sv]
// ----------------------------------------------------------------------------
// chpt_pkg: shared types and constants for the Hermite evaluator.
// Request codes, status codes, widths and the stage-to-stage payload struct.
// ----------------------------------------------------------------------------
package chpt_pkg;

  localparam int MaxPointsDef = 16;
  localparam int CoordW       = 32;
  localparam int ParamW       = 16;
  localparam int BasisW       = 34;   // signed Q.30 basis, |b| <= 1.5
  localparam int ProdW        = 66;   // coordinate times basis
  localparam int SumW         = 68;   // four products summed

  localparam logic [1:0] ReqWrPoint = 2'd0;
  localparam logic [1:0] ReqWrTang  = 2'd1;
  localparam logic [1:0] ReqEval    = 2'd2;
  localparam logic [1:0] ReqBad     = 2'd3;

  localparam logic [1:0] StOk  = 2'd0;
  localparam logic [1:0] StRej = 2'd1;
  localparam logic [1:0] StSat = 2'd2;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [BasisW-1:0] basis_t;
  typedef logic signed [SumW-1:0]   sum_t;

  // Per-item control carried beside the data.
  typedef struct packed {
    logic       eval;    // item produces vector results
    logic [1:0] status;  // status when not eval
  } ctl_t;

endpackage

[sv/chpt_basis.sv]
// ----------------------------------------------------------------------------
// chpt_basis: Hermite position and derivative basis from u.
// Two register stages: powers of u, then the eight basis values.
// ----------------------------------------------------------------------------
module chpt_basis (
  input  logic                        clk,
  input  logic                        en,
  input  logic [chpt_pkg::ParamW-1:0] u_in,
  output chpt_pkg::basis_t            hb_o [4],
  output chpt_pkg::basis_t            db_o [4]
);
  // u clamped to 2^15, so u fits in 16 bits, u^2 in 31, u^3 in 46.
  logic [15:0] u_c;
  logic [15:0] u_r;
  logic [30:0] u2_r;
  logic [45:0] u3_nxt;
  logic signed [49:0] u3s, u2s, us15, h0, h1, h2, h3;
  logic signed [36:0] u2q, usq, d0, d2, d3;

  assign u_c = (u_in > 16'd32768) ? 16'd32768 : u_in;

  always_ff @(posedge clk) begin
    if (en) begin
      u_r  <= u_c;
      u2_r <= {15'd0, u_c} * {15'd0, u_c};
    end
  end

  assign u3_nxt = {15'd0, u2_r} * {30'd0, u_r};
  assign u3s  = 50'(signed'({4'd0, u3_nxt}));
  assign u2s  = 50'(signed'({4'd0, u2_r, 15'd0}));
  assign us15 = 50'(signed'({4'd0, u_r, 30'd0}));
  assign h0 = 2*u3s - 3*u2s + (50'sd1 <<< 45);
  assign h1 = -2*u3s + 3*u2s;
  assign h2 = u3s - 2*u2s + us15;
  assign h3 = u3s - u2s;
  assign u2q = 37'(signed'({6'd0, u2_r}));
  assign usq = 37'(signed'({6'd0, u_r, 15'd0}));
  assign d0 = 6*u2q - 6*usq;
  assign d2 = 3*u2q - 4*usq + (37'sd1 <<< 30);
  assign d3 = 3*u2q - 2*usq;

  always_ff @(posedge clk) begin
    if (en) begin
      // Arithmetic shift floors; rounding is add half first.
      hb_o[0] <= chpt_pkg::BasisW'((h0 + 50'sd16384) >>> 15);
      hb_o[1] <= chpt_pkg::BasisW'((h1 + 50'sd16384) >>> 15);
      hb_o[2] <= chpt_pkg::BasisW'((h2 + 50'sd16384) >>> 15);
      hb_o[3] <= chpt_pkg::BasisW'((h3 + 50'sd16384) >>> 15);
      db_o[0] <= chpt_pkg::BasisW'(d0);
      db_o[1] <= chpt_pkg::BasisW'(-d0);
      db_o[2] <= chpt_pkg::BasisW'(d2);
      db_o[3] <= chpt_pkg::BasisW'(d3);
    end
  end
endmodule

[sv/chpt_dot.sv]
// ----------------------------------------------------------------------------
// chpt_dot: four-term dot product at full width; the top rounds it to Q16.16.
// Products registered, then the sum registered; the top rounds and saturates.
// ----------------------------------------------------------------------------
module chpt_dot (
  input  logic                   clk,
  input  logic                   en,
  input  chpt_pkg::coord_t       c_in [4],
  input  chpt_pkg::basis_t       b_in [4],
  output chpt_pkg::sum_t         sum_o
);
  logic signed [chpt_pkg::ProdW-1:0] p_r [4];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        p_r[i] <= chpt_pkg::ProdW'(c_in[i]) * chpt_pkg::ProdW'(b_in[i]);
      end
      sum_o <= chpt_pkg::SumW'(p_r[0]) + chpt_pkg::SumW'(p_r[1])
             + chpt_pkg::SumW'(p_r[2]) + chpt_pkg::SumW'(p_r[3]);
    end
  end
endmodule

[sv/cubic_hermite_point_and_tangent_top.sv]
// ----------------------------------------------------------------------------
// cubic_hermite_point_and_tangent_top: pipelined 3D Hermite evaluator.
// Table writes, segment evaluation of point and derivative, APB register.
// ----------------------------------------------------------------------------
//  channel  | ports                     | role
//  in       | in_valid/in_stall + data  | write point, write tangent, evaluate
//  out      | out_valid/out_stall + data| one result item per input item
//  cfg      | APB psel..pready          | point_count at address 0
//
// One item enters per cycle while the output is not stalled. An item passes
// six register stages: the table read, two basis stages, the multiplier
// stage, the adder stage and the round-and-saturate output register. Reset
// clears valid bits and point_count only; the tables are undefined until
// written. A stall on the output freezes the whole pipeline, so in_stall
// follows out_stall when the output register holds an item.
module cubic_hermite_point_and_tangent_top #(
  parameter int MAX_POINTS = chpt_pkg::MaxPointsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [3:0]  in_entry_index,
  input  logic [31:0] in_coord_x,
  input  logic [31:0] in_coord_y,
  input  logic [31:0] in_coord_z,
  input  logic [15:0] in_param_u,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_pos_x,
  output logic [31:0] out_pos_y,
  output logic [31:0] out_pos_z,
  output logic [31:0] out_slope_x,
  output logic [31:0] out_slope_y,
  output logic [31:0] out_slope_z,
  output logic [1:0]  out_status,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int IdxW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int Lat  = 6;

  // The table addresses follow the 4-bit entry field; entries past the table
  // are rejected before any write, and their reads are not used.
  logic [4:0] point_count_r;
  logic [4:0] cnt_eff;
  logic       en;
  logic [Lat-1:0] vld_r;
  chpt_pkg::ctl_t ctl_r [Lat];

  assign pready = 1'b1;
  assign prdata = (paddr == 1'b0) ? {27'd0, point_count_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_count_r <= '0;
    end else if (psel && penable && pwrite && paddr == 1'b0) begin
      point_count_r <= pwdata[4:0];
    end
  end

  // The pipe moves unless the output holds an item that is stalled.
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  logic acc;
  assign acc = in_valid && en;

  assign cnt_eff = (32'(point_count_r) > MAX_POINTS) ? 5'(MAX_POINTS) : point_count_r;

  // Classification at entry.
  chpt_pkg::ctl_t ctl_in;
  logic [4:0] k1;
  logic       in_tab, wr_ok;
  assign k1     = 5'(in_entry_index) + 5'd1;
  assign in_tab = 32'(in_entry_index) < MAX_POINTS;
  always_comb begin
    ctl_in.eval   = 1'b0;
    ctl_in.status = chpt_pkg::StRej;
    wr_ok         = 1'b0;
    case (in_req_type)
      chpt_pkg::ReqWrPoint, chpt_pkg::ReqWrTang: begin
        wr_ok = in_tab;
        ctl_in.status = in_tab ? chpt_pkg::StOk : chpt_pkg::StRej;
      end
      chpt_pkg::ReqEval: ctl_in.eval = (k1 < cnt_eff);
      default: ctl_in.status = chpt_pkg::StRej;
    endcase
  end

  // Tables: six memories, write at entry, two registered reads.
  chpt_pkg::coord_t px_m [MAX_POINTS], py_m [MAX_POINTS], pz_m [MAX_POINTS];
  chpt_pkg::coord_t tx_m [MAX_POINTS], ty_m [MAX_POINTS], tz_m [MAX_POINTS];
  chpt_pkg::coord_t cx_r [4], cy_r [4], cz_r [4];
  logic [IdxW-1:0] ia, ib, iw;
  assign ia = IdxW'(in_entry_index);
  assign ib = IdxW'(k1);
  assign iw = IdxW'(in_entry_index);

  always_ff @(posedge clk) begin
    if (acc && wr_ok) begin
      if (in_req_type == chpt_pkg::ReqWrPoint) begin
        px_m[iw] <= in_coord_x;
        py_m[iw] <= in_coord_y;
        pz_m[iw] <= in_coord_z;
      end else begin
        tx_m[iw] <= in_coord_x;
        ty_m[iw] <= in_coord_y;
        tz_m[iw] <= in_coord_z;
      end
    end
  end

  // Reads return the old contents, with no bypass: a write in the same cycle is
  // the same item, and the tables see writes from earlier items already.
  always_ff @(posedge clk) begin
    if (en) begin
      cx_r[0] <= px_m[ia]; cx_r[1] <= px_m[ib]; cx_r[2] <= tx_m[ia]; cx_r[3] <= tx_m[ib];
      cy_r[0] <= py_m[ia]; cy_r[1] <= py_m[ib]; cy_r[2] <= ty_m[ia]; cy_r[3] <= ty_m[ib];
      cz_r[0] <= pz_m[ia]; cz_r[1] <= pz_m[ib]; cz_r[2] <= tz_m[ia]; cz_r[3] <= tz_m[ib];
    end
  end

  // Basis: u registered once to line up with the table read, then two stages.
  logic [15:0] u_r;
  chpt_pkg::basis_t hb [4], db [4];
  always_ff @(posedge clk) begin
    if (en) u_r <= in_param_u;
  end
  chpt_basis u_basis (.clk(clk), .en(en), .u_in(u_r), .hb_o(hb), .db_o(db));

  // Coordinates delayed two stages to meet the basis.
  chpt_pkg::coord_t cx_d1 [4], cy_d1 [4], cz_d1 [4];
  chpt_pkg::coord_t cx_d2 [4], cy_d2 [4], cz_d2 [4];
  always_ff @(posedge clk) begin
    if (en) begin
      cx_d1 <= cx_r; cy_d1 <= cy_r; cz_d1 <= cz_r;
      cx_d2 <= cx_d1; cy_d2 <= cy_d1; cz_d2 <= cz_d1;
    end
  end

  chpt_pkg::sum_t s [6];
  chpt_dot u_px (.clk(clk), .en(en), .c_in(cx_d2), .b_in(hb), .sum_o(s[0]));
  chpt_dot u_py (.clk(clk), .en(en), .c_in(cy_d2), .b_in(hb), .sum_o(s[1]));
  chpt_dot u_pz (.clk(clk), .en(en), .c_in(cz_d2), .b_in(hb), .sum_o(s[2]));
  chpt_dot u_sx (.clk(clk), .en(en), .c_in(cx_d2), .b_in(db), .sum_o(s[3]));
  chpt_dot u_sy (.clk(clk), .en(en), .c_in(cy_d2), .b_in(db), .sum_o(s[4]));
  chpt_dot u_sz (.clk(clk), .en(en), .c_in(cz_d2), .b_in(db), .sum_o(s[5]));

  // Valid and control shift line; stage Lat-1 is the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[Lat-2:0], in_valid};
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      ctl_r[0] <= ctl_in;
      for (int i = 1; i < Lat; i++) ctl_r[i] <= ctl_r[i-1];
    end
  end

  // Round, saturate and register the result.
  logic [31:0] res_nxt [6];
  logic [5:0]  sat_v;
  logic [31:0] res_r [6];
  always_comb begin
    for (int j = 0; j < 6; j++) begin
      automatic chpt_pkg::sum_t r = (s[j] + (68'sd1 <<< 29)) >>> 30;
      if (r > 68'sd2147483647) begin
        res_nxt[j] = 32'h7fffffff; sat_v[j] = 1'b1;
      end else if (r < -68'sd2147483648) begin
        res_nxt[j] = 32'h80000000; sat_v[j] = 1'b1;
      end else begin
        res_nxt[j] = r[31:0]; sat_v[j] = 1'b0;
      end
    end
  end

  logic [1:0] st_r;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 6; j++)
        res_r[j] <= ctl_r[Lat-2].eval ? res_nxt[j] : 32'd0;
      st_r <= ctl_r[Lat-2].eval ? ((|sat_v) ? chpt_pkg::StSat : chpt_pkg::StOk)
                                : ctl_r[Lat-2].status;
    end
  end

  assign out_valid   = vld_r[Lat-1];
  assign out_pos_x   = res_r[0];
  assign out_pos_y   = res_r[1];
  assign out_pos_z   = res_r[2];
  assign out_slope_x = res_r[3];
  assign out_slope_y = res_r[4];
  assign out_slope_z = res_r[5];
  assign out_status  = st_r;

`ifndef NO_ASSERTIONS
  // A stalled output item stays in place.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status))
    else $error("output item lost under stall");
  // Input is stalled exactly when output is full and stalled.
  a_stall: assert property (@(posedge clk) in_stall === (out_valid && out_stall))
    else $error("input stall mismatch");
  // A rejected item carries all-zero vector data; out_pos_x is checked.
  a_rej: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == chpt_pkg::StRej |-> out_pos_x == 32'd0)
    else $error("rejected item with nonzero data");
`endif
endmodule

[test/hermite_result_checker.sv]
// ----------------------------------------------------------------------------
// hermite_result_checker: result predictor and comparator for the evaluator.
// Snoops the register port, the input channel and the result channel, keeps a
// private copy of the point and tangent tables, predicts every result item and
// compares it field by field with what the block returns, in order.
// ----------------------------------------------------------------------------
module hermite_result_checker
  import chpt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [3:0]  in_entry_index,
  input  logic [31:0] in_coord_x,
  input  logic [31:0] in_coord_y,
  input  logic [31:0] in_coord_z,
  input  logic [15:0] in_param_u,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] out_pos_x,
  input  logic [31:0] out_pos_y,
  input  logic [31:0] out_pos_z,
  input  logic [31:0] out_slope_x,
  input  logic [31:0] out_slope_y,
  input  logic [31:0] out_slope_z,
  input  logic [1:0]  out_status,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          mismatch_count,
  output int          awaited_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TableDepth = MaxPointsDef;
  localparam logic [0:0] AddrPointCount = 1'b0;

  typedef struct {
    logic [31:0] pos[3];
    logic [31:0] slope[3];
    logic [1:0]  status;
  } curve_sample_t;

  coord_t      pt_tab[3][TableDepth];
  coord_t      tg_tab[3][TableDepth];
  logic [4:0]  points_in_use;
  curve_sample_t awaited_samples[$];

  // Sum of four coordinate-times-basis products, rounded to Q16.16 and
  // clamped to the signed 32-bit range.
  function automatic logic [31:0] blend4(longint c0, longint c1, longint c2, longint c3,
                                         longint b0, longint b1, longint b2, longint b3,
                                         inout bit clipped);
    logic signed [127:0] acc;
    acc = c0 * b0 + c1 * b1 + c2 * b2 + c3 * b3;
    acc = (acc + 128'sh2000_0000) >>> 30;
    if (acc > 128'sd2147483647) begin
      clipped = 1'b1;
      return 32'h7fff_ffff;
    end
    if (acc < -128'sd2147483648) begin
      clipped = 1'b1;
      return 32'h8000_0000;
    end
    return acc[31:0];
  endfunction

  // Works out the result of one item and applies its table write.
  function automatic curve_sample_t hermite_response(logic [1:0] req, logic [3:0] k,
                                                     coord_t vx, coord_t vy, coord_t vz,
                                                     logic [15:0] u_raw);
    curve_sample_t s;
    int     eff;
    longint u, u2, u3, u2s, us;
    longint hb[4], db[4];
    bit     clipped;
    for (int j = 0; j < 3; j++) begin
      s.pos[j] = '0;
      s.slope[j] = '0;
    end
    s.status = StRej;
    clipped = 1'b0;
    eff = (points_in_use > TableDepth) ? TableDepth : points_in_use;
    case (req)
      ReqWrPoint, ReqWrTang: begin
        if (req == ReqWrPoint) begin
          pt_tab[0][k] = vx; pt_tab[1][k] = vy; pt_tab[2][k] = vz;
        end else begin
          tg_tab[0][k] = vx; tg_tab[1][k] = vy; tg_tab[2][k] = vz;
        end
        s.status = StOk;
      end
      ReqEval: begin
        if (int'(k) + 1 < eff) begin
          u = (u_raw > 16'd32768) ? 32768 : longint'(u_raw);
          u2  = u * u;
          u3  = u2 * u;
          u2s = u2 * 32768;
          us  = u * 32768;
          // Position basis is exact at Q.45, then rounded to Q.30.
          hb[0] = 2 * u3 - 3 * u2s + (longint'(1) << 45);
          hb[1] = -2 * u3 + 3 * u2s;
          hb[2] = u3 - 2 * u2s + us * 32768;
          hb[3] = u3 - u2s;
          for (int j = 0; j < 4; j++) hb[j] = (hb[j] + 16384) >>> 15;
          db[0] = 6 * u2 - 6 * us;
          db[1] = -db[0];
          db[2] = 3 * u2 - 4 * us + (longint'(1) << 30);
          db[3] = 3 * u2 - 2 * us;
          for (int j = 0; j < 3; j++) begin
            s.pos[j] = blend4(pt_tab[j][k], pt_tab[j][k+1], tg_tab[j][k], tg_tab[j][k+1],
                              hb[0], hb[1], hb[2], hb[3], clipped);
            s.slope[j] = blend4(pt_tab[j][k], pt_tab[j][k+1], tg_tab[j][k], tg_tab[j][k+1],
                                db[0], db[1], db[2], db[3], clipped);
          end
          s.status = clipped ? StSat : StOk;
        end
      end
      default: s.status = StRej;
    endcase
    return s;
  endfunction

  always @(posedge clk) begin
    curve_sample_t exp_s;
    logic [31:0]   got_pos[3];
    logic [31:0]   got_slope[3];
    bit            bad;
    if (!rst_n) begin
      points_in_use <= '0;
      awaited_samples.delete();
      mismatch_count <= 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == AddrPointCount)
        points_in_use <= pwdata[4:0];
      if (in_valid && !in_stall)
        awaited_samples.push_back(hermite_response(in_req_type, in_entry_index,
                                                   in_coord_x, in_coord_y, in_coord_z,
                                                   in_param_u));
      if (out_valid && !out_stall) begin
        got_pos   = '{out_pos_x, out_pos_y, out_pos_z};
        got_slope = '{out_slope_x, out_slope_y, out_slope_z};
        if (awaited_samples.size() == 0) begin
          if (mismatch_count < 10)
            $display("%t: result item arrived with none outstanding", $realtime);
          mismatch_count <= mismatch_count + 1;
        end else begin
          exp_s = awaited_samples.pop_front();
          bad = (exp_s.status != out_status);
          for (int j = 0; j < 3; j++)
            if (exp_s.pos[j] != got_pos[j] || exp_s.slope[j] != got_slope[j]) bad = 1'b1;
          if (bad) begin
            if (mismatch_count < 10) begin
              $display("%t: mismatch status exp %0d got %0d", $realtime, exp_s.status,
                       out_status);
              for (int j = 0; j < 3; j++)
                $display("  axis %0d pos exp %h got %h slope exp %h got %h", j,
                         exp_s.pos[j], got_pos[j], exp_s.slope[j], got_slope[j]);
            end
            mismatch_count <= mismatch_count + 1;
          end
        end
      end
    end
  end

  assign awaited_count = awaited_samples.size();

endmodule

[test/cubic_hermite_point_and_tangent_top_test.sv]
// ----------------------------------------------------------------------------
// cubic_hermite_point_and_tangent_top_test: testbench for the Hermite evaluator.
// Loads the point and tangent tables, evaluates segments under several point
// counts and idling patterns, and lets the checker judge every result item.
// ----------------------------------------------------------------------------
module cubic_hermite_point_and_tangent_top_test;
  import chpt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TableDepth = MaxPointsDef;
  localparam logic [0:0] AddrPointCount = 1'b0;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_req_type;
  logic [3:0]  in_entry_index;
  logic [31:0] in_coord_x, in_coord_y, in_coord_z;
  logic [15:0] in_param_u;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_pos_x, out_pos_y, out_pos_z;
  logic [31:0] out_slope_x, out_slope_y, out_slope_z;
  logic [1:0]  out_status;
  logic        psel, penable, pwrite;
  logic [0:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          mismatch_count;
  int          awaited_count;

  // Percentages of cycles in which the sender idles and the receiver stalls.
  int sender_idle_pct;
  int receiver_stall_pct;

  // Which table entries hold written data, and the point count we last set.
  // Evaluations are steered so that they never touch an unwritten entry.
  logic [TableDepth-1:0] point_loaded;
  logic [TableDepth-1:0] tangent_loaded;
  int                    count_setting;

  cubic_hermite_point_and_tangent_top DUT (.*);

  hermite_result_checker checker_i (.*);

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // The receiver decides afresh at every falling edge whether to stall.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < receiver_stall_pct);
  end

  // Hands one item to the block and returns once it has been accepted.
  task automatic send_item(logic [1:0] req, logic [3:0] k, logic [31:0] vx,
                           logic [31:0] vy, logic [31:0] vz, logic [15:0] u);
    while ($urandom_range(99) < sender_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid       <= 1'b1;
    in_req_type    <= req;
    in_entry_index <= k;
    in_coord_x     <= vx;
    in_coord_y     <= vy;
    in_coord_z     <= vz;
    in_param_u     <= u;
    if (req == ReqWrPoint) point_loaded[k] = 1'b1;
    if (req == ReqWrTang) tangent_loaded[k] = 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  // Lowers valid and waits until every outstanding result has come back,
  // plus a margin for the pipeline depth.
  task automatic drain_block();
    @(negedge clk);
    in_valid <= 1'b0;
    while (awaited_count != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // Register write: setup phase, then access phase.
  task automatic set_point_count(int value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrPointCount;
    pwdata  <= 32'(value);
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    count_setting = value;
  endtask

  // A coordinate that is often an extreme value and otherwise random.
  function automatic logic [31:0] pick_coord();
    case ($urandom_range(9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'(int'($urandom_range(131072)) - 65536);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [15:0] pick_param();
    case ($urandom_range(7))
      0: return 16'd0;
      1: return 16'd32768;
      2: return 16'($urandom_range(65535, 32769));
      default: return 16'($urandom_range(32768));
    endcase
  endfunction

  // Mostly well-formed traffic: table loads and evaluations of loaded
  // segments, with some out-of-range segments and unknown requests.
  task automatic random_item();
    int          eff;
    int          k;
    int          lo;
    bit          found;
    int          roll;
    logic [1:0]  req;
    eff = (count_setting > TableDepth) ? TableDepth : count_setting;
    roll = $urandom_range(99);
    if (roll < 3) begin
      send_item(ReqBad, 4'($urandom()), $urandom(), $urandom(), $urandom(), 16'($urandom()));
    end else if (roll < 38) begin
      req = $urandom_range(1) ? ReqWrTang : ReqWrPoint;
      send_item(req, 4'($urandom()), pick_coord(), pick_coord(), pick_coord(),
                16'($urandom()));
    end else begin
      found = 1'b0;
      k = $urandom_range(15);
      if (roll < 90) begin
        for (int n = 0; n < TableDepth && !found; n++) begin
          k = (k + 1) % TableDepth;
          if (k + 1 < eff && point_loaded[k] && point_loaded[k+1] &&
              tangent_loaded[k] && tangent_loaded[k+1]) found = 1'b1;
        end
      end
      if (!found) begin
        // An out-of-range segment reads nothing; entry 15 always is one.
        lo = (eff > 0) ? eff - 1 : 0;
        k = $urandom_range(15, lo);
      end
      send_item(ReqEval, 4'(k), $urandom(), $urandom(), $urandom(), pick_param());
    end
  endtask

  initial begin
    #4_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int counts[7];
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req_type = ReqWrPoint;
    in_entry_index = '0;
    in_coord_x = '0;
    in_coord_y = '0;
    in_coord_z = '0;
    in_param_u = '0;
    out_stall = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    point_loaded = '0;
    tangent_loaded = '0;
    count_setting = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part: extremes of the coordinates and the parameter.
    set_point_count(TableDepth);
    send_item(ReqWrPoint, 4'd0, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, 16'hffff);
    send_item(ReqWrPoint, 4'd1, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 16'h0000);
    send_item(ReqWrTang, 4'd0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h0001_0000, 16'h0);
    send_item(ReqWrTang, 4'd1, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_0000, 16'h0);
    // Large points and tangents push the slope into saturation.
    send_item(ReqEval, 4'd0, '0, '0, '0, 16'd0);
    send_item(ReqEval, 4'd0, '0, '0, '0, 16'd32768);
    send_item(ReqEval, 4'd0, '0, '0, '0, 16'd16384);
    send_item(ReqEval, 4'd0, '0, '0, '0, 16'hffff);
    send_item(ReqWrPoint, 4'd2, 32'h0001_0000, 32'h0002_0000, 32'hfffe_0000, 16'h0);
    send_item(ReqWrTang, 4'd2, 32'h0000_8000, 32'h0000_0001, 32'hffff_ffff, 16'h0);
    send_item(ReqWrPoint, 4'd15, 32'h1234_5678, 32'h0, 32'h0, 16'h0);
    send_item(ReqWrTang, 4'd15, 32'h0, 32'h8765_4321, 32'h0, 16'h0);
    send_item(ReqEval, 4'd1, '0, '0, '0, 16'd1);
    send_item(ReqEval, 4'd1, '0, '0, '0, 16'd32767);
    send_item(ReqEval, 4'd1, '0, '0, '0, 16'd32769);
    // Segment 15 can never be in range, and request code 3 is rejected.
    send_item(ReqEval, 4'd15, '0, '0, '0, 16'd100);
    send_item(ReqBad, 4'd3, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 16'hffff);
    drain_block();
    set_point_count(2);
    send_item(ReqEval, 4'd0, '0, '0, '0, 16'd12345);
    send_item(ReqEval, 4'd1, '0, '0, '0, 16'd12345);
    drain_block();

    // Random phases, each under its own point count and idling pattern.
    counts = '{16, 0, 31, 2, 9, 17, 1};
    for (int ph = 0; ph < 7; ph++) begin
      set_point_count(counts[ph]);
      case (ph % 4)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 72; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 72; end
        default: begin sender_idle_pct = 11; receiver_stall_pct = 11; end
      endcase
      for (int n = 0; n < 175; n++) begin
        random_item();
        // Once per phase the sender holds off until everything has come back.
        if (n == 90) drain_block();
      end
      drain_block();
    end

    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    drain_block();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && awaited_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
